>>> sv/tfdp_pkg.sv
package tfdp_pkg;

  // Width of one character and of one parsed value.
  localparam int CHAR_BITS  = 8;
  localparam int VALUE_BITS = 32;
  localparam int MAG_BITS   = VALUE_BITS - 1;
  // The accumulator times ten plus one digit fits in four more bits.
  localparam int ACC_BITS   = MAG_BITS + 4;
  localparam int DIGIT_BITS = 4;
  localparam int COUNT_BITS = 2;

  // Largest magnitude; accumulation saturates here.
  localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

  // Characters with a meaning to the parser.
  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;

  // Class of one input character, decided by the front end.
  typedef enum logic [2:0] {
    CLS_TERM  = 3'd0,
    CLS_SPACE = 3'd1,
    CLS_MINUS = 3'd2,
    CLS_DIGIT = 3'd3,
    CLS_OTHER = 3'd4
  } char_cls_t;

  // One classified word as it travels from the front end to the parser.
  typedef struct packed {
    logic                  valid;
    char_cls_t             cls;
    logic [DIGIT_BITS-1:0] digit;
  } char_word_t;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_t;

endpackage

>>> sv/two_field_decimal_parser_core.sv
// Two-field decimal parser.
// Input channel: one ASCII character per word on ch, taken when push is high
// and full is low. A zero character ends the string. Space-separated tokens
// are parsed as signed decimal integers; the first FIELD_COUNT tokens count.
// Result channel: when empty is low, first_value and second_value show the
// oldest finished string; the word is taken when pop is high and empty is low.
// Throughput: one character per cycle while the result queue has room, through
// a classifying front end, a two-word queue and a parser that handles one word
// per cycle. A terminating zero passes through the front queue to the parser,
// which writes its result into the result queue; words queued ahead delay it.
// Digit accumulation is a combinational shift-and-add by ten with saturation.
// Reset clears both queues and all parser state; empty is high and full is
// low afterward. When the receiver stalls, up to two results wait in the
// result queue; a further terminator then waits in the front queue, which
// fills with two words and raises full until pop frees room.
module two_field_decimal_parser_core
  import tfdp_pkg::*;
#(
  parameter int FIELD_COUNT = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [CHAR_BITS-1:0]         ch,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [VALUE_BITS-1:0] first_value,
  output logic signed [VALUE_BITS-1:0] second_value
);

  char_word_t word;
  logic       word_take;

  // Front end: classify characters and queue them.
  tfdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .ch        (ch),
    .word_out  (word),
    .word_take (word_take)
  );

  // Back end: parse tokens and queue results.
  tfdp_back #(
    .FIELD_COUNT (FIELD_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .word_in      (word),
    .word_take    (word_take),
    .empty        (empty),
    .pop          (pop),
    .first_value  (first_value),
    .second_value (second_value)
  );

endmodule

>>> sv/tfdp_front.sv
module tfdp_front
  import tfdp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [CHAR_BITS-1:0] ch,
  output char_word_t           word_out,
  input  logic                 word_take
);

  localparam int DEPTH = 2;

  char_word_t            word_in;
  char_word_t            store [DEPTH];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  wr_en;
  logic                  rd_en;

  // Classify the incoming character.
  always_comb begin
    word_in.valid = 1'b1;
    word_in.digit = '0;
    if (ch == CHAR_NUL) begin
      word_in.cls = CLS_TERM;
    end else if (ch == CHAR_SPACE) begin
      word_in.cls = CLS_SPACE;
    end else if (ch == CHAR_MINUS) begin
      word_in.cls = CLS_MINUS;
    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      word_in.cls   = CLS_DIGIT;
      word_in.digit = DIGIT_BITS'(ch - CHAR_ZERO);
    end else begin
      word_in.cls = CLS_OTHER;
    end
  end

  // Handshake of the short queue toward the parser.
  assign full  = (count == 2'(DEPTH));
  assign wr_en = push && !full;
  assign rd_en = word_out.valid && word_take;

  always_comb begin
    word_out       = store[rd_ptr];
    word_out.valid = (count != 2'd0);
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= word_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> sv/tfdp_back.sv
module tfdp_back
  import tfdp_pkg::*;
#(
  parameter int FIELD_COUNT = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  char_word_t                   word_in,
  output logic                         word_take,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [VALUE_BITS-1:0] first_value,
  output logic signed [VALUE_BITS-1:0] second_value
);

  localparam int DEPTH = 2;

  phase_t                  phase, phase_next;
  logic [MAG_BITS-1:0]     magnitude, magnitude_next;
  logic                    negative, negative_next;
  logic [COUNT_BITS-1:0]   token_count, token_count_next;
  logic [VALUE_BITS-1:0]   first_held, first_held_next;
  logic [VALUE_BITS-1:0]   second_held, second_held_next;

  logic [VALUE_BITS-1:0]   res_first [DEPTH];
  logic [VALUE_BITS-1:0]   res_second [DEPTH];
  logic                    res_wr_ptr;
  logic                    res_rd_ptr;
  logic [1:0]              res_count;
  logic                    res_wr;
  logic                    res_rd;

  logic [MAG_BITS-1:0]     mag_base;
  logic [ACC_BITS-1:0]     acc_wide;
  logic [MAG_BITS-1:0]     mag_acc;
  logic [VALUE_BITS-1:0]   tok_value;
  logic [VALUE_BITS-1:0]   fin_value;
  logic                    fin_pending;
  logic                    is_term;
  logic                    is_digit;
  logic                    is_space;
  logic                    do_finish;
  logic                    finish_numeric;
  logic [VALUE_BITS-1:0]   emit_first;
  logic [VALUE_BITS-1:0]   emit_second;

  // A terminator waits until the result queue has room; other words always go.
  assign is_term   = (word_in.cls == CLS_TERM);
  assign is_digit  = (word_in.cls == CLS_DIGIT);
  assign is_space  = (word_in.cls == CLS_SPACE);
  assign res_wr    = word_in.valid && is_term && (res_count != 2'(DEPTH));
  assign word_take = word_in.valid && (!is_term || (res_count != 2'(DEPTH)));

  // Accumulate one decimal digit as shift-and-add, saturating at the maximum.
  assign mag_base = (phase == PH_DIGITS) ? magnitude : '0;
  assign acc_wide = ({4'b0, mag_base} << 3) + ({4'b0, mag_base} << 1)
                    + ACC_BITS'(word_in.digit);
  assign mag_acc  = (acc_wide > ACC_BITS'(MAG_MAX)) ? MAG_MAX : acc_wide[MAG_BITS-1:0];

  // Signed value of the token in progress.
  assign tok_value = negative ? (VALUE_BITS'(0) - {1'b0, magnitude}) : {1'b0, magnitude};

  // Fields presented when the string ends, with any open token closed.
  assign fin_pending = (phase == PH_SIGN) || (phase == PH_DIGITS);
  assign fin_value   = (phase == PH_DIGITS) ? tok_value : '0;
  assign emit_first  = (fin_pending && token_count == COUNT_BITS'(0)) ? fin_value : first_held;
  assign emit_second = (FIELD_COUNT > 1 && fin_pending && token_count == COUNT_BITS'(1))
                       ? fin_value : second_held;

  // Token parsing state machine.
  always_comb begin
    phase_next       = phase;
    magnitude_next   = magnitude;
    negative_next    = negative;
    token_count_next = token_count;
    first_held_next  = first_held;
    second_held_next = second_held;
    do_finish        = 1'b0;
    finish_numeric   = 1'b0;

    if (word_take) begin
      if (is_term) begin
        phase_next       = PH_IDLE;
        magnitude_next   = '0;
        negative_next    = 1'b0;
        token_count_next = '0;
        first_held_next  = '0;
        second_held_next = '0;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (is_space || token_count >= COUNT_BITS'(FIELD_COUNT)) begin
              phase_next = PH_IDLE;
            end else if (word_in.cls == CLS_MINUS) begin
              negative_next = 1'b1;
              phase_next    = PH_SIGN;
            end else if (is_digit) begin
              magnitude_next = mag_acc;
              phase_next     = PH_DIGITS;
            end else begin
              do_finish  = 1'b1;
              phase_next = PH_SKIP;
            end
          end
          PH_SIGN: begin
            if (is_digit) begin
              magnitude_next = mag_acc;
              phase_next     = PH_DIGITS;
            end else begin
              do_finish  = 1'b1;
              phase_next = is_space ? PH_IDLE : PH_SKIP;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              magnitude_next = mag_acc;
            end else begin
              do_finish      = 1'b1;
              finish_numeric = 1'b1;
              phase_next     = is_space ? PH_IDLE : PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (is_space) begin
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase

        // Close the token: store its value in its field and count it.
        if (do_finish) begin
          if (token_count == COUNT_BITS'(0)) begin
            first_held_next = finish_numeric ? tok_value : '0;
          end else if (token_count == COUNT_BITS'(1) && FIELD_COUNT > 1) begin
            second_held_next = finish_numeric ? tok_value : '0;
          end
          token_count_next = token_count + COUNT_BITS'(1);
          magnitude_next   = '0;
          negative_next    = 1'b0;
        end
      end
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      magnitude   <= '0;
      negative    <= 1'b0;
      token_count <= '0;
      first_held  <= '0;
      second_held <= '0;
    end else begin
      phase       <= phase_next;
      magnitude   <= magnitude_next;
      negative    <= negative_next;
      token_count <= token_count_next;
      first_held  <= first_held_next;
      second_held <= second_held_next;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_first[res_wr_ptr]  <= emit_first;
      res_second[res_wr_ptr] <= emit_second;
    end
  end

  // Result queue pointers and fill count.
  assign empty  = (res_count == 2'd0);
  assign res_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      if (res_wr) begin
        res_wr_ptr <= ~res_wr_ptr;
      end
      if (res_rd) begin
        res_rd_ptr <= ~res_rd_ptr;
      end
      if (res_wr && !res_rd) begin
        res_count <= res_count + 2'd1;
      end else if (res_rd && !res_wr) begin
        res_count <= res_count - 2'd1;
      end
    end
  end

  assign first_value  = res_first[res_rd_ptr];
  assign second_value = res_second[res_rd_ptr];

endmodule

>>> sv/tfdp_checker.sv
module tfdp_checker
  import tfdp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  push,
  input logic                  full,
  input logic [CHAR_BITS-1:0]  ch,
  input logic                  empty,
  input logic                  pop,
  input logic [VALUE_BITS-1:0] first_value,
  input logic [VALUE_BITS-1:0] second_value
);

  // Both queues come out of reset empty.
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not clear after reset");

  // A waiting result word holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(first_value) && $stable(second_value)))
    else $error("result word changed while stalled");

  // The input queue fills only through an accepted character.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted character");

  // A result cannot appear so soon after reset that the input side could not yet have taken anything.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> !$past(rst, 2))
    else $error("result appeared too soon after reset");

  // A character that is taken carries known bits.
  a_ch_known: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> !$isunknown(ch))
    else $error("character unknown when accepted");

endmodule

bind two_field_decimal_parser_core tfdp_checker u_tfdp_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .ch           (ch),
  .empty        (empty),
  .pop          (pop),
  .first_value  (first_value),
  .second_value (second_value)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tfdp_pkg::*;

  localparam int FIELDS         = 2;
  localparam int PHASE_CHARS    = 420;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT    = 40;

  localparam logic signed [VALUE_BITS-1:0] SAT_POS = {1'b0, MAG_MAX};
  localparam logic signed [VALUE_BITS-1:0] SAT_NEG = -SAT_POS;

  // One parsed string: the two values the block should report.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] first_v;
    logic signed [VALUE_BITS-1:0] second_v;
  } pair_t;

  // Directed strings; the terminating zero is appended when sent.
  typedef struct {
    string text;
    bit    typed;
    int    want_first;
    int    want_second;
  } vector_t;

  vector_t vectors[4] = '{
    '{"",                       1'b1, 0,          0},
    '{"-",                      1'b1, 0,          0},
    '{"1.5 -x 3",               1'b0, 0,          0},
    '{"2147483647 -2147483648", 1'b1, 2147483647, -2147483647}
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         push = 1'b0;
  logic [CHAR_BITS-1:0]         ch = '0;
  logic                         pop = 1'b0;
  logic                         full;
  logic                         empty;
  logic signed [VALUE_BITS-1:0] first_value;
  logic signed [VALUE_BITS-1:0] second_value;

  // Parser mirror state.
  phase_t                  pp_phase;
  logic [MAG_BITS-1:0]     pp_mag;
  logic                    pp_neg;
  logic [COUNT_BITS-1:0]   pp_count;
  logic [VALUE_BITS-1:0]   pp_first;
  logic [VALUE_BITS-1:0]   pp_second;

  pair_t                   pending_pairs[$];
  logic [CHAR_BITS-1:0]    text_buf[$];
  string                   near_max = "214748364";

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_request = 1'b0;
  int  error_count = 0;
  int  chars_accepted = 0;
  int  pairs_checked = 0;
  int  saturated_pairs = 0;
  int  full_stall_cycles = 0;

  always #5 clk = ~clk;

  two_field_decimal_parser_core DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .ch           (ch),
    .empty        (empty),
    .pop          (pop),
    .first_value  (first_value),
    .second_value (second_value)
  );

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // Clear the mirror; every string starts from this state.
  function automatic void clear_parser();
    pp_phase  = PH_IDLE;
    pp_mag    = '0;
    pp_neg    = 1'b0;
    pp_count  = '0;
    pp_first  = '0;
    pp_second = '0;
  endfunction

  function automatic bit is_digit_char(input logic [CHAR_BITS-1:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  // Store the value of the token just ended and count it.
  function automatic void close_token(input logic numeric);
    logic [VALUE_BITS-1:0] v;
    v = '0;
    if (numeric) begin
      v = pp_neg ? -{1'b0, pp_mag} : {1'b0, pp_mag};
    end
    if (pp_count == 0) begin
      pp_first = v;
    end else if (pp_count == 1 && FIELDS > 1) begin
      pp_second = v;
    end
    pp_count = pp_count + 1'b1;
    pp_mag   = '0;
    pp_neg   = 1'b0;
  endfunction

  // Add one decimal digit, holding at the largest magnitude.
  function automatic void take_digit(input logic [CHAR_BITS-1:0] c);
    logic [3:0] d;
    d = 4'(c - CHAR_ZERO);
    if (pp_mag > (MAG_MAX - d) / 10) begin
      pp_mag = MAG_MAX;
    end else begin
      pp_mag = MAG_BITS'(pp_mag * 10 + d);
    end
  endfunction

  // Advance the mirror by one character; returns 1 when a string ends.
  function automatic bit parse_char(input logic [CHAR_BITS-1:0] c, output pair_t res);
    res = '0;
    if (c == CHAR_NUL) begin
      if (pp_phase == PH_SIGN) begin
        close_token(1'b0);
      end else if (pp_phase == PH_DIGITS) begin
        close_token(1'b1);
      end
      res.first_v  = pp_first;
      res.second_v = pp_second;
      clear_parser();
      return 1'b1;
    end
    case (pp_phase)
      PH_IDLE: begin
        if (c != CHAR_SPACE && pp_count < FIELDS) begin
          if (c == CHAR_MINUS) begin
            pp_neg   = 1'b1;
            pp_phase = PH_SIGN;
          end else if (is_digit_char(c)) begin
            pp_mag = '0;
            take_digit(c);
            pp_phase = PH_DIGITS;
          end else begin
            close_token(1'b0);
            pp_phase = PH_SKIP;
          end
        end
      end
      PH_SIGN: begin
        if (is_digit_char(c)) begin
          pp_mag = '0;
          take_digit(c);
          pp_phase = PH_DIGITS;
        end else begin
          close_token(1'b0);
          pp_phase = (c == CHAR_SPACE) ? PH_IDLE : PH_SKIP;
        end
      end
      PH_DIGITS: begin
        if (is_digit_char(c)) begin
          take_digit(c);
        end else begin
          close_token(1'b1);
          pp_phase = (c == CHAR_SPACE) ? PH_IDLE : PH_SKIP;
        end
      end
      default: begin
        if (c == CHAR_SPACE) begin
          pp_phase = PH_IDLE;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // Any byte that is neither the terminator nor a space.
  function automatic logic [CHAR_BITS-1:0] junk_byte();
    logic [CHAR_BITS-1:0] c;
    do c = CHAR_BITS'($urandom_range(1, 255)); while (c == CHAR_SPACE);
    return c;
  endfunction

  function automatic void add_digits(input int n);
    repeat (n) text_buf.push_back(CHAR_ZERO + CHAR_BITS'($urandom_range(0, 9)));
  endfunction

  // One token: optional sign, a body of some kind, sometimes a trailing tail.
  function automatic void add_token();
    int kind;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 2) == 0) text_buf.push_back(CHAR_MINUS);
    if (kind == 0) begin
      if ($urandom_range(0, 1) == 0) text_buf.push_back(junk_byte());
    end else if (kind == 1) begin
      // Values right around the saturation point.
      repeat ($urandom_range(0, 1)) text_buf.push_back(CHAR_ZERO);
      for (int i = 0; i < near_max.len(); i++) text_buf.push_back(near_max[i]);
      add_digits($urandom_range(1, 2));
    end else if (kind == 2) begin
      add_digits($urandom_range(10, 12));
    end else begin
      add_digits($urandom_range(1, 6));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text_buf.push_back(junk_byte());
    end
  endfunction

  // A well-formed string of zero to four tokens.
  function automatic void build_line();
    int ntok;
    ntok = $urandom_range(0, 4);
    repeat ($urandom_range(0, 2)) text_buf.push_back(CHAR_SPACE);
    for (int t = 0; t < ntok; t++) begin
      if (t != 0) repeat ($urandom_range(1, 3)) text_buf.push_back(CHAR_SPACE);
      add_token();
    end
    repeat ($urandom_range(0, 1)) text_buf.push_back(CHAR_SPACE);
    text_buf.push_back(CHAR_NUL);
  endfunction

  // Arbitrary bytes, terminators included, then a closing terminator.
  function automatic void build_noise();
    int r;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        text_buf.push_back(CHAR_SPACE);
      end else if (r == 1) begin
        text_buf.push_back(CHAR_MINUS);
      end else begin
        text_buf.push_back(CHAR_BITS'($urandom_range(0, 255)));
      end
    end
    text_buf.push_back(CHAR_NUL);
  endfunction

  // Offer one word and wait until it is taken; the mirror tracks it on acceptance.
  task automatic feed_char(input logic [CHAR_BITS-1:0] c, input bit use_typed,
                           input pair_t typed_pair);
    pair_t pred;
    bit    done;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    ch   <= c;
    do @(posedge clk); while (full);
    chars_accepted++;
    done = parse_char(c, pred);
    if (done) pending_pairs.push_back(use_typed ? typed_pair : pred);
  endtask

  task automatic send_buf(input bit use_typed, input pair_t typed_pair);
    foreach (text_buf[i]) feed_char(text_buf[i], use_typed, typed_pair);
    text_buf.delete();
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic drain_results();
    push <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  // Receiver: check each word taken, then decide pop for the next cycle.
  initial begin
    pair_t want;
    int    hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_pairs.size() == 0) begin
          report_mismatch($sformatf("result word %0d/%0d with no string pending",
                                    first_value, second_value));
        end else begin
          want = pending_pairs.pop_front();
          pairs_checked++;
          if (first_value !== want.first_v) begin
            report_mismatch($sformatf("first_value got %0d want %0d",
                                      first_value, want.first_v));
          end
          if (second_value !== want.second_v) begin
            report_mismatch($sformatf("second_value got %0d want %0d",
                                      second_value, want.second_v));
          end
          if (want.first_v == SAT_POS || want.first_v == SAT_NEG ||
              want.second_v == SAT_POS || want.second_v == SAT_NEG) begin
            saturated_pairs++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long; also counts full stalls.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (!rst && push && full) full_stall_cycles++;
    end
    $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus: directed strings, then four pacing phases of random strings.
  initial begin
    pair_t typed_pair;
    int    phase_end;
    clear_parser();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (vectors[v]) begin
      for (int i = 0; i < vectors[v].text.len(); i++) text_buf.push_back(vectors[v].text[i]);
      text_buf.push_back(CHAR_NUL);
      typed_pair.first_v  = vectors[v].want_first;
      typed_pair.second_v = vectors[v].want_second;
      send_buf(vectors[v].typed, typed_pair);
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 10;
          recv_stall_pct = 10;
        end
      endcase
      phase_end = chars_accepted + PHASE_CHARS;
      while (chars_accepted < phase_end) begin
        if ($urandom_range(0, 99) < 15) begin
          build_noise();
        end else begin
          build_line();
        end
        send_buf(1'b0, '0);
      end
      // Long receiver hold while strings keep coming, so the input backs up.
      if (p == 0) begin
        hold_request = 1'b1;
        repeat (14) begin
          build_line();
          send_buf(1'b0, '0);
        end
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d parsed strings from %0d characters; %0d carried a saturated value.",
             pairs_checked, chars_accepted, saturated_pairs);
    $display("Input held off by full for %0d cycles across four pacing phases.",
             full_stall_cycles);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
